### src/rmrt_pkg.sv
`default_nettype none
package rmrt_pkg;

  localparam int OP_W = 3;
  localparam int ID_W = 32;
  localparam int NODE_IN_W = 8;
  localparam int ROT_W = 32;
  localparam int CODE_W = 2;

  localparam logic [OP_W-1:0] OP_ACTIVATE = 3'd0;
  localparam logic [OP_W-1:0] OP_JOIN     = 3'd1;
  localparam logic [OP_W-1:0] OP_ROTATE   = 3'd2;
  localparam logic [OP_W-1:0] OP_QUERY    = 3'd3;
  localparam logic [OP_W-1:0] OP_DISSOLVE = 3'd4;

  localparam logic [CODE_W-1:0] MODE_INACTIVE  = 2'd0;
  localparam logic [CODE_W-1:0] MODE_ACTIVE    = 2'd1;
  localparam logic [CODE_W-1:0] MODE_DISSOLVED = 2'd2;

  localparam logic [CODE_W-1:0] ST_OK      = 2'd0;
  localparam logic [CODE_W-1:0] ST_RANGE   = 2'd1;
  localparam logic [CODE_W-1:0] ST_SESSION = 2'd2;

  localparam logic [CODE_W-1:0] ROLE_NONE  = 2'd0;
  localparam logic [CODE_W-1:0] ROLE_WORK  = 2'd1;
  localparam logic [CODE_W-1:0] ROLE_WATCH = 2'd2;

  typedef struct packed {
    logic load;
    logic scan_en;
    logic exec;
  } rmrt_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic count_over;
  } rmrt_sts_t;

endpackage
`default_nettype wire

### src/rally_membership_role_table_top.sv
// Channel  Dir  Beat content (low bit first)
// s_axis   in   op[2:0], session_id[34:3], node[42:35]
// m_axis   out  status, role, mode_now, member_total, rotation_total, anchor_now
//
// One beat at a time: accept, scan the member table one slot per cycle
// (stops on a hit), then update state and load the output register.
// The table scan runs through the single read port of the member memory.
// A new beat is accepted while the previous result waits on m_tready.
// rst is synchronous: mode inactive, counts, id and anchor zero.
`default_nettype none
module rally_membership_role_table_top #(
  parameter int NODE_LIMIT   = 64,
  parameter int MEMBER_SLOTS = 16,
  localparam int NW = $clog2(NODE_LIMIT),
  localparam int CW = $clog2(MEMBER_SLOTS + 1),
  localparam int OUT_BITS = 3 * rmrt_pkg::CODE_W + CW + rmrt_pkg::ROT_W + NW,
  localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  // op, session_id, node
  input  wire logic [47:0]       s_tdata,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  // status, role, mode_now, member_total, rotation_total, anchor_now
  output logic [OUT_W-1:0]       m_tdata
);
  import rmrt_pkg::*;

  rmrt_cmd_t cmd;
  rmrt_sts_t sts;

  logic [CODE_W-1:0] status;
  logic [CODE_W-1:0] role;
  logic [CODE_W-1:0] mode_now;
  logic [CW-1:0]     member_total;
  logic [ROT_W-1:0]  rotation_total;
  logic [NW-1:0]     anchor_now;

  rmrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rmrt_dp #(
    .NODE_LIMIT   (NODE_LIMIT),
    .MEMBER_SLOTS (MEMBER_SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .op             (s_tdata[OP_W-1:0]),
    .session_id     (s_tdata[OP_W+ID_W-1:OP_W]),
    .node           (s_tdata[OP_W+ID_W+NODE_IN_W-1:OP_W+ID_W]),
    .sts            (sts),
    .status         (status),
    .role           (role),
    .mode_now       (mode_now),
    .member_total   (member_total),
    .rotation_total (rotation_total),
    .anchor_now     (anchor_now)
  );

  assign m_tdata = OUT_W'({anchor_now, rotation_total, member_total, mode_now, role, status});

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("beat accepted while busy");

  a_exec_loads_out: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> m_tvalid)
    else $error("result not presented after update");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    !sts.count_over)
    else $error("member count above slot count");

  a_role_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (role != ROLE_NONE)) |-> (status == ST_OK))
    else $error("role given with error status");

endmodule
`default_nettype wire

### src/rmrt_ctrl.sv
`default_nettype none
module rmrt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire rmrt_pkg::rmrt_sts_t sts,
  output rmrt_pkg::rmrt_cmd_t    cmd
);
  import rmrt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       exec_go;

  assign in_ready = (state == S_IDLE);
  assign exec_go  = (state == S_EXEC) && (!out_valid || out_ready);

  always_comb begin
    cmd.load    = in_valid && (state == S_IDLE);
    cmd.scan_en = (state == S_SCAN);
    cmd.exec    = exec_go;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_done) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (exec_go) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (exec_go) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

### src/rmrt_dp.sv
`default_nettype none
module rmrt_dp #(
  parameter int NODE_LIMIT   = 64,
  parameter int MEMBER_SLOTS = 16,
  localparam int NW = $clog2(NODE_LIMIT),
  localparam int CW = $clog2(MEMBER_SLOTS + 1)
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire rmrt_pkg::rmrt_cmd_t                 cmd,
  input  wire logic [rmrt_pkg::OP_W-1:0]           op,
  input  wire logic [rmrt_pkg::ID_W-1:0]           session_id,
  input  wire logic [rmrt_pkg::NODE_IN_W-1:0]      node,
  output rmrt_pkg::rmrt_sts_t                      sts,
  output logic [rmrt_pkg::CODE_W-1:0]              status,
  output logic [rmrt_pkg::CODE_W-1:0]              role,
  output logic [rmrt_pkg::CODE_W-1:0]              mode_now,
  output logic [CW-1:0]                            member_total,
  output logic [rmrt_pkg::ROT_W-1:0]               rotation_total,
  output logic [NW-1:0]                            anchor_now
);
  import rmrt_pkg::*;

  localparam int IW = (MEMBER_SLOTS > 1) ? $clog2(MEMBER_SLOTS) : 1;
  localparam logic [NODE_IN_W:0] LIMIT = (NODE_IN_W + 1)'(NODE_LIMIT);
  localparam logic [CW-1:0] SLOTS = CW'(MEMBER_SLOTS);

  logic [OP_W-1:0]      op_r;
  logic [ID_W-1:0]      id_r;
  logic [NODE_IN_W-1:0] node_r;

  logic [CODE_W-1:0] mode;
  logic [ID_W-1:0]   sess;
  logic [NW-1:0]     anchor;
  logic [CW-1:0]     count;
  logic [ROT_W-1:0]  rot;

  logic [CODE_W-1:0] mode_next;
  logic [ID_W-1:0]   sess_next;
  logic [NW-1:0]     anchor_next;
  logic [CW-1:0]     count_next;
  logic [ROT_W-1:0]  rot_next;
  logic [CODE_W-1:0] status_next;
  logic [CODE_W-1:0] role_next;
  logic              wr_en;

  logic [NW-1:0] mem [MEMBER_SLOTS];
  logic [NW-1:0] rd_data;
  logic [CW-1:0] scan_idx;
  logic [IW-1:0] rd_idx;
  logic          rd_vld;
  logic          found;
  logic [IW-1:0] found_idx;
  logic          issue;
  logic          node_ok;
  logic          match;

  assign issue   = cmd.scan_en && !found && (scan_idx < count);
  assign node_ok = ({1'b0, node_r} < LIMIT);
  assign match   = (mode == MODE_ACTIVE) && (sess == id_r);

  always_comb begin
    sts.scan_done  = !rd_vld && (found || (scan_idx >= count));
    sts.count_over = (count > SLOTS);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op;
      id_r   <= session_id;
      node_r <= node;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[count[IW-1:0]] <= node_r[NW-1:0];
    if (issue) begin
      rd_data <= mem[scan_idx[IW-1:0]];
      rd_idx  <= scan_idx[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      rd_vld   <= 1'b0;
      found    <= 1'b0;
    end else if (cmd.load) begin
      scan_idx <= '0;
      rd_vld   <= 1'b0;
      found    <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (issue) scan_idx <= scan_idx + CW'(1);
      if (rd_vld && !found && (NODE_IN_W'(rd_data) == node_r)) begin
        found     <= 1'b1;
        found_idx <= rd_idx;
      end
    end
  end

  always_comb begin
    mode_next   = mode;
    sess_next   = sess;
    anchor_next = anchor;
    count_next  = count;
    rot_next    = rot;
    status_next = ST_OK;
    role_next   = ROLE_NONE;
    wr_en       = 1'b0;
    case (op_r)
      OP_ACTIVATE: begin
        if (!node_ok) begin
          status_next = ST_RANGE;
        end else if (match) begin
          anchor_next = node_r[NW-1:0];
        end else begin
          count_next  = '0;
          rot_next    = '0;
          sess_next   = id_r;
          anchor_next = node_r[NW-1:0];
          mode_next   = MODE_ACTIVE;
        end
      end
      OP_JOIN: begin
        if (!node_ok) begin
          status_next = ST_RANGE;
        end else if (!match) begin
          status_next = ST_SESSION;
        end else if (found) begin
          status_next = ST_OK;
        end else if (count >= SLOTS) begin
          status_next = ST_SESSION;
        end else begin
          wr_en      = cmd.exec;
          count_next = count + CW'(1);
        end
      end
      OP_ROTATE: begin
        if (!match) status_next = ST_SESSION;
        else rot_next = rot + ROT_W'(1);
      end
      OP_QUERY: begin
        if ((mode == MODE_ACTIVE) && found) begin
          role_next = (found_idx[0] ^ rot[0]) ? ROLE_WATCH : ROLE_WORK;
        end
      end
      OP_DISSOLVE: begin
        if (mode != MODE_ACTIVE) begin
          if (!((mode == MODE_DISSOLVED) && (sess == id_r))) status_next = ST_SESSION;
        end else if (sess != id_r) begin
          status_next = ST_SESSION;
        end else begin
          mode_next = MODE_DISSOLVED;
        end
      end
      default: status_next = ST_SESSION;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_INACTIVE;
      sess   <= '0;
      anchor <= '0;
      count  <= '0;
      rot    <= '0;
    end else if (cmd.exec) begin
      mode   <= mode_next;
      sess   <= sess_next;
      anchor <= anchor_next;
      count  <= count_next;
      rot    <= rot_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status         <= status_next;
      role           <= role_next;
      mode_now       <= mode_next;
      member_total   <= count_next;
      rotation_total <= rot_next;
      anchor_now     <= anchor_next;
    end
  end

endmodule
`default_nettype wire
